// ===== rtl/rle8sd_pkg.sv =====
// Package for the RLE8 bitmap span decoder: coordinate widths, parser phase
// type, escape codes, register indexes and the saturating cursor helpers.
// No dependencies.
package rle8sd_pkg;

  localparam int COORD_BITS = 16;
  localparam int XW         = COORD_BITS;
  localparam int YW         = COORD_BITS + 1;
  localparam int TW         = (YW > 17) ? YW : 17;
  localparam int OUT_W      = 16;
  localparam int CFG_W      = 16;

  localparam logic [0:0] CFG_CLIP_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_CLIP_HEIGHT = 1'b1;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [7:0] {
    PH_FIRST = 8'b0000_0001,
    PH_COLOR = 8'b0000_0010,
    PH_ESC   = 8'b0000_0100,
    PH_DX    = 8'b0000_1000,
    PH_DY    = 8'b0001_0000,
    PH_LIT   = 8'b0010_0000,
    PH_PAD   = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } phase_t;

  function automatic logic [XW-1:0] x_add(input logic [XW-1:0] x, input logic [7:0] n);
    logic [XW:0] s;
    s = {1'b0, x} + (XW+1)'(n);
    return s[XW] ? {XW{1'b1}} : s[XW-1:0];
  endfunction

  function automatic logic signed [YW-1:0] y_sub(input logic signed [YW-1:0] y,
                                                 input logic [7:0] n);
    logic signed [YW:0] d;
    d = (YW+1)'(y) - $signed((YW+1)'(n));
    return (d[YW] != d[YW-1]) ? {1'b1, {(YW-1){1'b0}}} : d[YW-1:0];
  endfunction

endpackage

// ===== rtl/rle8_bitmap_span_decoder_unit.sv =====
// Top level of the RLE8 bitmap span decoder: byte parser, cursor and span
// result register. Depends on rle8sd_pkg.
//
// Takes one byte of a BMP RLE8 stream per cycle while the input is not stalled
// and emits clipped spans (x, y, length, palette index) plus an end marker.
// Every byte is parsed in the cycle it is accepted and its span, if any,
// appears in the next cycle from the result register. The input stalls only
// while a result sits in the result register and the output side stalls.
module rle8_bitmap_span_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [rle8sd_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_image_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rle8sd_pkg::OUT_W-1:0]  out_span_x,
  output logic [rle8sd_pkg::OUT_W-1:0]  out_span_y,
  output logic [7:0]                    out_span_length,
  output logic [7:0]                    out_color_index,
  output logic                          out_image_end
);

  localparam int XW = rle8sd_pkg::XW;
  localparam int YW = rle8sd_pkg::YW;
  localparam int TW = rle8sd_pkg::TW;
  localparam int OW = rle8sd_pkg::OUT_W;

  logic [15:0]               clip_w_r, clip_h_r;
  rle8sd_pkg::phase_t        phase_r, phase_nxt, ph0;
  logic [XW-1:0]             cx_r, cx_nxt, x0;
  logic signed [YW-1:0]      cy_r, cy_nxt, y0;
  logic [7:0]                pend_r, pend_nxt, pend0, pend_dec;
  logic                      pad_r, pad_nxt, pad0;

  logic                      in_acc;
  logic signed [TW-1:0]      top_w, y_top, y0_ext;
  logic [TW-1:0]             x0_ext, w_ext, room;
  logic                      vis, x_in;
  logic [7:0]                run_len;

  logic                      res_vld;
  logic [OW-1:0]             res_x, res_y;
  logic [7:0]                res_len, res_col;
  logic                      res_end;

  logic                      ov_r, ov_nxt;
  logic [OW-1:0]             ox_r, oy_r;
  logic [7:0]                olen_r, ocol_r;
  logic                      oend_r;

  assign in_stall = ov_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    top_w  = $signed(TW'(clip_h_r)) - $signed(TW'(1));
    y_top  = (top_w > $signed(TW'({XW{1'b1}}))) ? $signed(TW'({XW{1'b1}})) : top_w;
    x0     = in_image_start ? '0 : cx_r;
    y0     = in_image_start ? y_top[YW-1:0] : cy_r;
    ph0    = in_image_start ? rle8sd_pkg::PH_FIRST : phase_r;
    pend0  = in_image_start ? 8'd0 : pend_r;
    pad0   = in_image_start ? 1'b0 : pad_r;
    y0_ext = TW'(y0);
    x0_ext = TW'(x0);
    w_ext  = TW'(clip_w_r);
    vis    = ~y0_ext[TW-1] && (y0_ext < $signed(TW'(clip_h_r)));
    x_in   = x0_ext < w_ext;
    room   = w_ext - x0_ext;
    run_len = (TW'(pend0) < room) ? pend0 : room[7:0];
    pend_dec = pend0 - 8'd1;
  end

  always_comb begin
    phase_nxt = ph0;
    cx_nxt    = x0;
    cy_nxt    = y0;
    pend_nxt  = pend0;
    pad_nxt   = pad0;
    res_vld   = 1'b0;
    res_x     = x0_ext[OW-1:0];
    res_y     = y0_ext[OW-1:0];
    res_len   = 8'd1;
    res_col   = in_data_byte;
    res_end   = 1'b0;
    unique case (ph0)
      rle8sd_pkg::PH_FIRST: begin
        if (in_data_byte == 8'd0) begin
          phase_nxt = rle8sd_pkg::PH_ESC;
        end else begin
          pend_nxt  = in_data_byte;
          phase_nxt = rle8sd_pkg::PH_COLOR;
        end
      end
      rle8sd_pkg::PH_COLOR: begin
        if (vis) begin
          res_vld = x_in;
          res_len = run_len;
          cx_nxt  = rle8sd_pkg::x_add(x0, pend0);
        end
        pend_nxt  = 8'd0;
        phase_nxt = rle8sd_pkg::PH_FIRST;
      end
      rle8sd_pkg::PH_ESC: begin
        if (in_data_byte == rle8sd_pkg::ESC_EOL) begin
          cx_nxt    = '0;
          cy_nxt    = rle8sd_pkg::y_sub(y0, 8'd1);
          phase_nxt = rle8sd_pkg::PH_FIRST;
        end else if (in_data_byte == rle8sd_pkg::ESC_EOB) begin
          phase_nxt = rle8sd_pkg::PH_DONE;
          res_vld   = 1'b1;
          res_x     = '0;
          res_y     = '0;
          res_len   = 8'd0;
          res_col   = 8'd0;
          res_end   = 1'b1;
        end else if (in_data_byte == rle8sd_pkg::ESC_DELTA) begin
          phase_nxt = rle8sd_pkg::PH_DX;
        end else begin
          pend_nxt  = in_data_byte;
          pad_nxt   = in_data_byte[0];
          phase_nxt = rle8sd_pkg::PH_LIT;
        end
      end
      rle8sd_pkg::PH_DX: begin
        cx_nxt    = rle8sd_pkg::x_add(x0, in_data_byte);
        phase_nxt = rle8sd_pkg::PH_DY;
      end
      rle8sd_pkg::PH_DY: begin
        cy_nxt    = rle8sd_pkg::y_sub(y0, in_data_byte);
        phase_nxt = rle8sd_pkg::PH_FIRST;
      end
      rle8sd_pkg::PH_LIT: begin
        if (vis) begin
          res_vld = x_in;
          cx_nxt  = rle8sd_pkg::x_add(x0, 8'd1);
        end
        pend_nxt = pend_dec;
        if (pend_dec == 8'd0) begin
          phase_nxt = pad0 ? rle8sd_pkg::PH_PAD : rle8sd_pkg::PH_FIRST;
        end
      end
      rle8sd_pkg::PH_PAD: begin
        pad_nxt   = 1'b0;
        phase_nxt = rle8sd_pkg::PH_FIRST;
      end
      rle8sd_pkg::PH_DONE: begin
      end
      default: begin
        phase_nxt = rle8sd_pkg::PH_FIRST;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (in_acc) begin
      ov_nxt = res_vld;
    end else if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_w_r <= '0;
      clip_h_r <= '0;
      phase_r  <= rle8sd_pkg::PH_FIRST;
      cx_r     <= '0;
      cy_r     <= '0;
      pend_r   <= '0;
      pad_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rle8sd_pkg::CFG_CLIP_WIDTH) begin
          clip_w_r <= cfg_wdata;
        end else begin
          clip_h_r <= cfg_wdata;
        end
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
        cx_r    <= cx_nxt;
        cy_r    <= cy_nxt;
        pend_r  <= pend_nxt;
        pad_r   <= pad_nxt;
      end
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_vld) begin
      ox_r   <= res_x;
      oy_r   <= res_y;
      olen_r <= res_len;
      ocol_r <= res_col;
      oend_r <= res_end;
    end
  end

  assign out_valid       = ov_r;
  assign out_span_x      = ox_r;
  assign out_span_y      = oy_r;
  assign out_span_length = olen_r;
  assign out_color_index = ocol_r;
  assign out_image_end   = oend_r;

  a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_span_length == 8'd0 && out_span_x == '0)
    else $error("end beat carries span data");

  a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_image_end |-> out_span_length != 8'd0)
    else $error("empty span emitted");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ov_r && out_stall)
    else $error("input stalled without a held result");

  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_image_start |=> !out_valid)
    else $error("result after first byte of image");

endmodule

// ===== test/tb_rle8_bitmap_span_decoder_unit.sv =====
// Testbench for rle8_bitmap_span_decoder_unit: drives BMP RLE8 byte streams under
// several clip settings and checks every span against a cycle-free decoder model.
// Depends on rle8sd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_rle8_bitmap_span_decoder_unit;

  localparam logic [7:0] RLE_ESCAPE   = 8'd0;
  localparam int         X_LIMIT      = (1 << rle8sd_pkg::XW) - 1;
  localparam int         Y_FLOOR      = -(1 << rle8sd_pkg::XW);
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         PHASE_BYTES  = 20;

  typedef struct packed {
    logic [rle8sd_pkg::OUT_W-1:0] x;
    logic [rle8sd_pkg::OUT_W-1:0] y;
    logic [7:0]                   len;
    logic [7:0]                   color;
    logic                         done;
  } span_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } item_t;

  class span_scoreboard;
    logic [rle8sd_pkg::CFG_W-1:0]    clip_w;
    logic [rle8sd_pkg::CFG_W-1:0]    clip_h;
    rle8sd_pkg::phase_t              phase;
    logic [rle8sd_pkg::XW-1:0]       cur_x;
    logic signed [rle8sd_pkg::YW-1:0] cur_y;
    logic [7:0]                      pend;
    logic                            pad;
    span_t                           want_q[$];
    int                              bytes_seen;
    int                              spans_seen;
    int                              ends_seen;
    int                              mismatches;

    function new();
      clip_w = '0;
      clip_h = '0;
      phase = rle8sd_pkg::PH_FIRST;
      cur_x = '0;
      cur_y = '0;
      pend = '0;
      pad = 1'b0;
      bytes_seen = 0;
      spans_seen = 0;
      ends_seen = 0;
      mismatches = 0;
    endfunction

    function void set_clip(logic [rle8sd_pkg::CFG_W-1:0] w, logic [rle8sd_pkg::CFG_W-1:0] h);
      clip_w = w;
      clip_h = h;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function logic [rle8sd_pkg::XW-1:0] step_x(logic [rle8sd_pkg::XW-1:0] x, logic [7:0] n);
      int s;
      s = int'(x) + int'(n);
      if (s > X_LIMIT) s = X_LIMIT;
      return s[rle8sd_pkg::XW-1:0];
    endfunction

    function logic signed [rle8sd_pkg::YW-1:0] step_y(logic signed [rle8sd_pkg::YW-1:0] y,
                                                      logic [7:0] n);
      int s;
      s = int'(y) - int'(n);
      if (s < Y_FLOOR) s = Y_FLOOR;
      return s[rle8sd_pkg::YW-1:0];
    endfunction

    function bit row_on();
      return int'(cur_y) >= 0 && int'(cur_y) < int'(clip_h);
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      span_t s;
      bit    emit;
      int    room;
      int    top;
      s = '0;
      emit = 0;
      bytes_seen++;
      if (start) begin
        top = int'(clip_h) - 1;
        if (top > X_LIMIT) top = X_LIMIT;
        cur_x = '0;
        cur_y = top[rle8sd_pkg::YW-1:0];
        phase = rle8sd_pkg::PH_FIRST;
        pend = '0;
        pad = 1'b0;
      end
      case (phase)
        rle8sd_pkg::PH_FIRST: begin
          if (b == RLE_ESCAPE) begin
            phase = rle8sd_pkg::PH_ESC;
          end else begin
            pend = b;
            phase = rle8sd_pkg::PH_COLOR;
          end
        end
        rle8sd_pkg::PH_COLOR: begin
          if (row_on()) begin
            if (int'(cur_x) < int'(clip_w)) begin
              room = int'(clip_w) - int'(cur_x);
              s.x = cur_x[rle8sd_pkg::OUT_W-1:0];
              s.y = cur_y[rle8sd_pkg::OUT_W-1:0];
              s.len = (int'(pend) < room) ? pend : room[7:0];
              s.color = b;
              emit = 1;
            end
            cur_x = step_x(cur_x, pend);
          end
          pend = '0;
          phase = rle8sd_pkg::PH_FIRST;
        end
        rle8sd_pkg::PH_ESC: begin
          if (b == rle8sd_pkg::ESC_EOL) begin
            cur_x = '0;
            cur_y = step_y(cur_y, 8'd1);
            phase = rle8sd_pkg::PH_FIRST;
          end else if (b == rle8sd_pkg::ESC_EOB) begin
            s.done = 1'b1;
            emit = 1;
            phase = rle8sd_pkg::PH_DONE;
          end else if (b == rle8sd_pkg::ESC_DELTA) begin
            phase = rle8sd_pkg::PH_DX;
          end else begin
            pend = b;
            pad = b[0];
            phase = rle8sd_pkg::PH_LIT;
          end
        end
        rle8sd_pkg::PH_DX: begin
          cur_x = step_x(cur_x, b);
          phase = rle8sd_pkg::PH_DY;
        end
        rle8sd_pkg::PH_DY: begin
          cur_y = step_y(cur_y, b);
          phase = rle8sd_pkg::PH_FIRST;
        end
        rle8sd_pkg::PH_LIT: begin
          if (row_on()) begin
            if (int'(cur_x) < int'(clip_w)) begin
              s.x = cur_x[rle8sd_pkg::OUT_W-1:0];
              s.y = cur_y[rle8sd_pkg::OUT_W-1:0];
              s.len = 8'd1;
              s.color = b;
              emit = 1;
            end
            cur_x = step_x(cur_x, 8'd1);
          end
          pend = pend - 8'd1;
          if (pend == 8'd0) phase = pad ? rle8sd_pkg::PH_PAD : rle8sd_pkg::PH_FIRST;
        end
        rle8sd_pkg::PH_PAD: begin
          pad = 1'b0;
          phase = rle8sd_pkg::PH_FIRST;
        end
        default: begin
        end
      endcase
      if (emit) want_q.push_back(s);
    endfunction

    function void flag(string what, span_t want, span_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected x=%0d y=%0d len=%0d color=%0d end=%0b", what, want.x, want.y,
                 want.len, want.color, want.done);
        $display("  got x=%0d y=%0d len=%0d color=%0d end=%0b", got.x, got.y, got.len,
                 got.color, got.done);
      end
    endfunction

    function void check_span(span_t got);
      span_t want;
      if (want_q.size() == 0) begin
        flag("span with nothing expected", '0, got);
        return;
      end
      want = want_q.pop_front();
      if (got.done) ends_seen++;
      else spans_seen++;
      if (got.x !== want.x || got.y !== want.y || got.len !== want.len ||
          got.color !== want.color || got.done !== want.done) begin
        flag("span mismatch", want, got);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [0:0]                   cfg_index = rle8sd_pkg::CFG_CLIP_WIDTH;
  logic [rle8sd_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   in_data_byte = '0;
  logic                         in_image_start = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [rle8sd_pkg::OUT_W-1:0] out_span_x;
  logic [rle8sd_pkg::OUT_W-1:0] out_span_y;
  logic [7:0]                   out_span_length;
  logic [7:0]                   out_color_index;
  logic                         out_image_end;

  span_scoreboard sb = new();
  item_t          feed_q[$];
  bit             mark_start;
  int             gap_pct;
  int             stall_pct;
  int             stall_left;
  int             idle_cycles;
  int             settings_done;

  rle8_bitmap_span_decoder_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_image_start  (in_image_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_span_x      (out_span_x),
    .out_span_y      (out_span_y),
    .out_span_length (out_span_length),
    .out_color_index (out_color_index),
    .out_image_end   (out_image_end)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    span_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x = out_span_x;
      got.y = out_span_y;
      got.len = out_span_length;
      got.color = out_color_index;
      got.done = out_image_end;
      sb.check_span(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a beat", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic void put_byte(int v);
    item_t it;
    it.data = v[7:0];
    it.start = mark_start;
    mark_start = 0;
    feed_q.push_back(it);
  endfunction

  function automatic void put_delta(int dx, int dy);
    put_byte(RLE_ESCAPE);
    put_byte(rle8sd_pkg::ESC_DELTA);
    put_byte(dx);
    put_byte(dy);
  endfunction

  // Bytes ahead of any image start, odd and even literals, clipped full run, end marker.
  function automatic void add_directed();
    mark_start = 0;
    put_byte(8'h03); put_byte(8'haa);
    put_byte(RLE_ESCAPE); put_byte(8'h03);
    put_byte(8'h11); put_byte(8'h22); put_byte(8'h33); put_byte(8'h00);
    mark_start = 1;
    put_delta(37, 1);
    put_byte(8'hff); put_byte(8'h7e);
    put_byte(RLE_ESCAPE); put_byte(rle8sd_pkg::ESC_EOL);
    put_byte(RLE_ESCAPE); put_byte(8'h04);
    put_byte(8'h00); put_byte(8'hff); put_byte(8'h80); put_byte(8'h01);
    put_byte(RLE_ESCAPE); put_byte(rle8sd_pkg::ESC_EOB);
    put_byte(8'h55);
  endfunction

  // Walk x in wide moves up to and past the clip edge, then y down below the bottom row.
  function automatic void add_saturation_walk();
    mark_start = 1;
    repeat (20) put_delta(255, 0);
    put_byte(8'hff); put_byte(8'h3c);
    put_delta(255, 0);
    put_byte(8'h04); put_byte(8'h3d);
    put_byte(RLE_ESCAPE); put_byte(8'h03);
    put_byte(8'h01); put_byte(8'h02); put_byte(8'h03); put_byte(8'h00);
    repeat (4) put_delta(0, 255);
    put_byte(RLE_ESCAPE); put_byte(rle8sd_pkg::ESC_EOL);
    put_byte(8'h02); put_byte(8'h44);
    put_byte(RLE_ESCAPE); put_byte(rle8sd_pkg::ESC_EOB);
  endfunction

  function automatic void add_image();
    int kind;
    int n;
    mark_start = ($urandom_range(0, 19) != 0);
    repeat ($urandom_range(3, 20)) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20);
        put_byte(n);
        put_byte($urandom_range(0, 255));
      end else if (kind < 62) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 9);
        put_byte(RLE_ESCAPE);
        put_byte(n);
        repeat (n) put_byte($urandom_range(0, 255));
        if (n % 2) put_byte($urandom_range(0, 255));
      end else if (kind < 74) begin
        put_byte(RLE_ESCAPE);
        put_byte(rle8sd_pkg::ESC_EOL);
      end else if (kind < 84) begin
        put_delta(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2));
      end else if (kind < 93) begin
        put_byte($urandom_range(0, 255));
      end else begin
        mark_start = 1;
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      put_byte(RLE_ESCAPE);
      put_byte(rle8sd_pkg::ESC_EOB);
      repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 255));
    end
  endfunction

  task automatic run_feed();
    item_t it;
    foreach (feed_q[i]) begin
      it = feed_q[i];
      if ($urandom_range(0, 99) < gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data_byte <= it.data;
      in_image_start <= it.start;
      do @(posedge clk); while (in_stall);
      sb.note_byte(it.data, it.start);
    end
    in_valid <= 1'b0;
    feed_q.delete();
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_clip(int w, int h);
    cfg_we <= 1'b1;
    cfg_index <= rle8sd_pkg::CFG_CLIP_WIDTH;
    cfg_wdata <= w[rle8sd_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_index <= rle8sd_pkg::CFG_CLIP_HEIGHT;
    cfg_wdata <= h[rle8sd_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_clip(w[rle8sd_pkg::CFG_W-1:0], h[rle8sd_pkg::CFG_W-1:0]);
    settings_done++;
  endtask

  initial begin
    int w;
    int h;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      case (ph)
        0: begin w = 40; h = 4; end
        1: begin w = 5200; h = 1; end
        2: begin w = 16; h = 6; end
        3: begin w = 65535; h = 65535; end
        4: begin w = 0; h = 0; end
        5: begin w = 1; h = 1; end
        6: begin w = 300; h = 3; end
        default: begin
          w = $urandom_range(0, 400);
          h = $urandom_range(0, 24);
        end
      endcase
      if (ph >= 8) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = 5 * $urandom_range(0, 5);
        stall_pct = 5 * $urandom_range(0, 5);
      end
      write_clip(w, h);
      if (ph == 0) add_directed();
      else if (ph == 1) add_saturation_walk();
      else while (feed_q.size() < PHASE_BYTES) add_image();
      run_feed();
    end
    settle();
    if (sb.pending() != 0) $display("%0d expected spans never arrived", sb.pending());
    $display("Fed %0d stream bytes under %0d clip settings", sb.bytes_seen, settings_done);
    $display("Checked %0d spans and %0d end markers, %0d mismatches", sb.spans_seen,
             sb.ends_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
